[hdl/sgd_pkg.sv]
package sgd_pkg;

  localparam int UNIT_COUNT  = 3;
  localparam int GRID_COLS   = 6;
  localparam int RAM_BYTES   = 16;

  localparam int GRID_ROWS   = 2 * UNIT_COUNT;
  localparam int CELL_COUNT  = GRID_ROWS * GRID_COLS;
  localparam int DIGITS_USED = 12;
  localparam int UNIT_STRIDE = 2 * GRID_COLS;
  // digits actually loaded per unit
  localparam int DIG_N       = (UNIT_STRIDE < DIGITS_USED) ? UNIT_STRIDE : DIGITS_USED;
  localparam int DIG_SLOTS   = 16;

  localparam int CELL_AW     = $clog2(CELL_COUNT);
  localparam int DIG_AW      = $clog2(DIG_N);
  localparam int DCNT_W      = $clog2(DIG_N + 1);
  localparam int UNIT_CW     = (UNIT_COUNT > 4) ? 3 : 2;
  localparam int ADDR_W      = $clog2(RAM_BYTES);

  localparam logic [2:0] MODE_SET   = 3'd0;
  localparam logic [2:0] MODE_OR    = 3'd1;
  localparam logic [2:0] MODE_CLR   = 3'd2;
  localparam logic [2:0] MODE_ZERO  = 3'd3;
  localparam logic [2:0] MODE_FILL  = 3'd4;
  localparam logic [2:0] MODE_FLUSH = 3'd5;

  typedef struct packed {
    logic               wr_en;
    logic [CELL_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
    logic               rd_en;
    logic [CELL_AW-1:0] rd_addr;
    logic               wipe;
    logic               wipe_ones;
  } cs_req_t;

endpackage

[hdl/sgd_ram.sv]
module sgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/sgd_cell_store.sv]
module sgd_cell_store import sgd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cs_req_t    req,
  output logic [7:0] rd_data
);

  logic [CELL_COUNT-1:0] valid;
  logic                  fill_ones;
  logic                  rd_valid;
  logic [7:0]            ram_q;

  // entries not written since the last wipe read as the wipe value
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      fill_ones <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      if (req.wipe) begin
        valid     <= '0;
        fill_ones <= req.wipe_ones;
      end else if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid <= valid[req.rd_addr];
      end
    end
  end

  sgd_ram #(
    .WIDTH(8),
    .DEPTH(CELL_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (req.wr_en),
    .waddr(req.wr_addr),
    .wdata(req.wr_data),
    .re   (req.rd_en),
    .raddr(req.rd_addr),
    .rdata(ram_q)
  );

  assign rd_data = rd_valid ? ram_q : {8{fill_ones}};

endmodule

[hdl/segment_grid_to_driver_ram.sv]
// Set cell, zero grid and fill grid: a single request taken in idle. OR / clear bits: read-modify-write
// through the cell RAM's registered read, with the write done in the RMW state. Flush: per unit,
// load the unit's digits one RAM read a cycle, then emit 16 beats at one per cycle while the
// output does not stall. Not ready while an item is in progress.
// Reset (synchronous, active high) makes the whole grid read as zero at once; no clearing pass.
module segment_grid_to_driver_ram import sgd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic [2:0] mode,
  input  logic [2:0] column,
  input  logic [2:0] row,
  input  logic [7:0] segments,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [1:0] unit,
  output logic [3:0] ram_addr,
  output logic [7:0] ram_byte,
  output logic       last
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RMW  = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state;

  cs_req_t             req;
  logic [7:0]          rd_data;
  logic                cmd_fire;
  logic                cell_ok;
  logic [7:0]          cell_idx_full;
  logic [CELL_AW-1:0]  cell_idx;

  logic [CELL_AW-1:0]  rmw_addr;
  logic                rmw_or;
  logic [7:0]          rmw_seg;

  logic [CELL_AW-1:0]  base;
  logic [DCNT_W-1:0]   dcnt;
  logic                ld_vld;
  logic [DIG_AW-1:0]   ld_ptr;
  logic [UNIT_CW-1:0]  unit_cnt;
  logic [ADDR_W-1:0]   addr_cnt;
  logic                emit_load;

  logic [7:0]          dig [DIG_N];
  logic [7:0]          pad [DIG_SLOTS];
  logic [7:0]          byte_calc;
  logic [2:0]          seg_sel;

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign emit_load = (state == ST_EMIT) && (!res_valid || res_ready);

  assign cell_ok       = (4'(column) < 4'(GRID_COLS)) && (5'(row) < 5'(GRID_ROWS));
  assign cell_idx_full = 8'(row) * 8'(GRID_COLS) + 8'(column);
  assign cell_idx      = cell_idx_full[CELL_AW-1:0];

  always_comb begin
    req = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          case (mode)
            MODE_SET: begin
              req.wr_en   = cell_ok;
              req.wr_addr = cell_idx;
              req.wr_data = segments;
            end
            MODE_OR, MODE_CLR: begin
              req.rd_en   = cell_ok;
              req.rd_addr = cell_idx;
            end
            MODE_ZERO: begin
              req.wipe = 1'b1;
            end
            MODE_FILL: begin
              req.wipe      = 1'b1;
              req.wipe_ones = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_RMW: begin
        req.wr_en   = 1'b1;
        req.wr_addr = rmw_addr;
        req.wr_data = rmw_or ? (rd_data | rmw_seg) : (rd_data & ~rmw_seg);
      end
      ST_LOAD: begin
        req.rd_en   = (dcnt < DCNT_W'(DIG_N));
        req.rd_addr = base + CELL_AW'(dcnt);
      end
      default: ;
    endcase
  end

  sgd_cell_store u_store (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rd_data(rd_data)
  );

  // digits past the loaded ones read as zero
  for (genvar d = 0; d < DIG_SLOTS; d++) begin : g_pad
    if (d < DIG_N) begin : g_used
      assign pad[d] = dig[d];
    end else begin : g_unused
      assign pad[d] = '0;
    end
  end

  // byte 2*s+h: bit j is segment bit 7-s of digit j+8h
  assign seg_sel = addr_cnt[ADDR_W-1:1];
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      byte_calc[j] = addr_cnt[0] ? pad[j + 8][~seg_sel] : pad[j][~seg_sel];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      ld_vld    <= 1'b0;
      base      <= '0;
      dcnt      <= '0;
      unit_cnt  <= '0;
      addr_cnt  <= '0;
    end else begin
      ld_vld <= (state == ST_LOAD) && req.rd_en;
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (emit_load) begin
        res_valid <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            if ((mode inside {MODE_OR, MODE_CLR}) && cell_ok) begin
              state <= ST_RMW;
            end else if (mode == MODE_FLUSH) begin
              state    <= ST_LOAD;
              base     <= '0;
              dcnt     <= '0;
              unit_cnt <= '0;
            end
          end
        end
        ST_RMW: begin
          state <= ST_IDLE;
        end
        ST_LOAD: begin
          if (dcnt < DCNT_W'(DIG_N)) begin
            dcnt <= dcnt + 1'b1;
          end else begin
            state    <= ST_EMIT;
            addr_cnt <= '0;
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            addr_cnt <= addr_cnt + 1'b1;
            if (addr_cnt == ADDR_W'(RAM_BYTES - 1)) begin
              if (unit_cnt == UNIT_CW'(UNIT_COUNT - 1)) begin
                state <= ST_IDLE;
              end else begin
                state    <= ST_LOAD;
                unit_cnt <= unit_cnt + 1'b1;
                base     <= base + CELL_AW'(UNIT_STRIDE);
                dcnt     <= '0;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      rmw_addr <= cell_idx;
      rmw_or   <= (mode == MODE_OR);
      rmw_seg  <= segments;
    end
    ld_ptr <= dcnt[DIG_AW-1:0];
    if (ld_vld) begin
      dig[ld_ptr] <= rd_data;
    end
    if (emit_load) begin
      unit     <= unit_cnt[1:0];
      ram_addr <= addr_cnt;
      ram_byte <= byte_calc;
      last     <= (unit_cnt == UNIT_CW'(UNIT_COUNT - 1)) &&
                  (addr_cnt == ADDR_W'(RAM_BYTES - 1));
    end
  end

  // read-modify-write only follows an accepted item
  a_rmw_after_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_RMW |-> $past(state) == ST_IDLE)
    else $error("rmw entered without an accepted item");

  // load data returns only while the unit's digits are being loaded
  a_load_return: assert property (@(posedge clk) disable iff (rst)
    ld_vld |-> state == ST_LOAD)
    else $error("load data returned outside load");

  a_dcnt_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> dcnt <= DCNT_W'(DIG_N))
    else $error("digit counter out of range");

  // a new beat is only produced while emitting
  a_beat_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_EMIT)
    else $error("beat produced outside emit");

endmodule
